// File: rtl/spct_pkg.sv
// Shared types and constants of the shape pair collision test unit.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package spct_pkg;

	// Q15.8 coordinates
	localparam int COORD_WIDTH = 24;
	localparam int FRAC_BITS   = 8;

	// derived datapath widths
	localparam int DIFF_W = COORD_WIDTH + 1;      // difference of two coordinates
	localparam int SQ_W   = 2 * DIFF_W;           // square or sum of two squares
	localparam int ROOT_W = COORD_WIDTH + 1;      // floor root of SQ_W bits
	localparam int EXT_W  = COORD_WIDTH + 4;      // contact before saturation
	localparam int LEN_W  = COORD_WIDTH + 3;      // dist + ra - rb
	localparam int NUM_W  = DIFF_W + LEN_W;       // d * (dist + ra - rb)
	localparam int DEN_W  = ROOT_W + 1;           // 2 * dist
	localparam int QUO_W  = COORD_WIDTH + 2;      // quotient bits kept

	// five front stages, root stages, a product and a magnitude stage, quotient stages, output
	localparam int LATENCY = 5 + ROOT_W + 2 + QUO_W + 1;

	typedef enum logic [2:0] {
		OP_RECT_RECT     = 3'd0,
		OP_CIRCLE_CIRCLE = 3'd1,
		OP_RECT_CIRCLE   = 3'd2,
		OP_RECT_POINT    = 3'd3,
		OP_CIRCLE_POINT  = 3'd4,
		OP_POINT_POINT   = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]                    operation;
		logic signed [COORD_WIDTH-1:0] a_x0;
		logic signed [COORD_WIDTH-1:0] a_y0;
		logic signed [COORD_WIDTH-1:0] a_x1;
		logic signed [COORD_WIDTH-1:0] a_y1;
		logic signed [COORD_WIDTH-1:0] b_x0;
		logic signed [COORD_WIDTH-1:0] b_y0;
		logic signed [COORD_WIDTH-1:0] b_x1;
		logic signed [COORD_WIDTH-1:0] b_y1;
	} cmd_word_t;

	typedef struct packed {
		logic                          hit;
		logic signed [COORD_WIDTH-1:0] contact_x;
		logic signed [COORD_WIDTH-1:0] contact_y;
	} result_word_t;

	// word state carried alongside the root pipeline
	typedef struct packed {
		logic                          hit;
		logic                          need_div;
		logic signed [EXT_W-1:0]       cx;
		logic signed [EXT_W-1:0]       cy;
		logic signed [DIFF_W-1:0]      dx;
		logic signed [DIFF_W-1:0]      dy;
		logic signed [COORD_WIDTH-1:0] ra;
		logic signed [COORD_WIDTH-1:0] rb;
		logic signed [COORD_WIDTH-1:0] ax0;
		logic signed [COORD_WIDTH-1:0] ay0;
	} sq_side_t;

	// word state carried alongside the quotient pipelines
	typedef struct packed {
		logic                          hit;
		logic                          need_div;
		logic signed [EXT_W-1:0]       cx;
		logic signed [EXT_W-1:0]       cy;
		logic signed [COORD_WIDTH-1:0] ax0;
		logic signed [COORD_WIDTH-1:0] ay0;
		logic                          sgn_x;
		logic                          sgn_y;
	} dv_side_t;

endpackage

// File: rtl/spct_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on spct_pkg for widths.
`timescale 1ns / 1ps

module spct_isqrt
	import spct_pkg::*;
(
	input  logic              clk,
	input  logic [SQ_W-1:0]   radicand,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] rem_q [ROOT_W];
	logic [SQ_W-1:0] res_q [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [SQ_W-1:0] rem_in;
		logic [SQ_W-1:0] res_in;
		logic [SQ_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = radicand;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rem_q[k] <= rem_in - trial;
				res_q[k] <= (res_in >> 1) + BIT;
			end else begin
				rem_q[k] <= rem_in;
				res_q[k] <= res_in >> 1;
			end
		end
	end

	assign root = res_q[ROOT_W-1][ROOT_W-1:0];

endmodule

// File: rtl/spct_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on spct_pkg for widths.
`timescale 1ns / 1ps

module spct_div
	import spct_pkg::*;
(
	input  logic             clk,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [QUO_W-1:0] quotient,
	output logic             rem_nz
);

	logic [NUM_W-1:0] rem_q [QUO_W];
	logic [DEN_W-1:0] den_q [QUO_W];
	logic [QUO_W-1:0] quo_q [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [NUM_W-1:0] shifted;

		if (k == 0) begin : g_first
			assign rem_in = dividend;
			assign den_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign shifted = NUM_W'(den_in) << (QUO_W - 1 - k);

		always_ff @(posedge clk) begin
			den_q[k] <= den_in;
			if (rem_in >= shifted) begin
				rem_q[k] <= rem_in - shifted;
				quo_q[k] <= {quo_in[QUO_W-2:0], 1'b1};
			end else begin
				rem_q[k] <= rem_in;
				quo_q[k] <= {quo_in[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q[QUO_W-1];
	assign rem_nz   = (rem_q[QUO_W-1] != '0);

endmodule

// File: rtl/shape_pair_collision_test_unit.sv
// Top level of the shape pair collision test unit: front stages, root and quotient pipelines.
// Depends on spct_pkg, spct_isqrt and spct_div.
`timescale 1ns / 1ps

// Stateless 2-D collision test of one shape pair (rect, circle or point) in signed
// Q15.8. A word is taken whenever start is high; busy never rises, so one word a cycle
// goes in. Every word comes out in order, with done high for one cycle; the receiver
// cannot hold results off and needs none of that. The latency is set by the root
// pipeline (one root bit a stage) followed by the quotient pipelines (one quotient bit a
// stage) that the circle-circle contact point needs; all other operations ride the same
// pipeline so every word has the same latency. On a miss, or on an unused operation
// code, hit is 0 and both contact coordinates are 0. Contacts are saturated.
module shape_pair_collision_test_unit
	import spct_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  cmd_word_t    cmd,
	output logic         done,
	output result_word_t result
);

	localparam int CW = COORD_WIDTH;

	// integer part rounded toward zero
	function automatic logic signed [CW-1:0] trunc_int(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] sh;
		sh = v >>> FRAC_BITS;
		if (v[CW-1] && (v[FRAC_BITS-1:0] != '0))
			sh = sh + CW'(1);
		return sh;
	endfunction

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
		logic signed [EXT_W-1:0] cmax;
		logic signed [EXT_W-1:0] cmin;
		cmax = {{(EXT_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
		cmin = ~cmax;
		if (v > cmax)
			return cmax[CW-1:0];
		else if (v < cmin)
			return cmin[CW-1:0];
		else
			return v[CW-1:0];
	endfunction

	// the pipeline never stalls
	assign busy = 1'b0;

	// ---------------------------------------------------------------- stage 1: capture
	logic      vld_s1;
	cmd_word_t in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			in_s1 <= cmd;
	end

	// ---------------------------------------------------------------- stage 2: differences
	logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	assign ax0 = $signed(in_s1.a_x0);
	assign ay0 = $signed(in_s1.a_y0);
	assign ax1 = $signed(in_s1.a_x1);
	assign ay1 = $signed(in_s1.a_y1);
	assign bx0 = $signed(in_s1.b_x0);
	assign by0 = $signed(in_s1.b_y0);
	assign bx1 = $signed(in_s1.b_x1);
	assign by1 = $signed(in_s1.b_y1);

	logic signed [CW-1:0]     rr_lo_x, rr_hi_x, rr_lo_y, rr_hi_y;
	logic signed [DIFF_W-1:0] rr_sum_x, rr_sum_y;

	always_comb begin
		rr_lo_x  = (ax0 > bx0) ? ax0 : bx0;
		rr_hi_x  = (ax1 < bx1) ? ax1 : bx1;
		rr_lo_y  = (ay0 > by0) ? ay0 : by0;
		rr_hi_y  = (ay1 < by1) ? ay1 : by1;
		rr_sum_x = DIFF_W'(rr_lo_x) + DIFF_W'(rr_hi_x);
		rr_sum_y = DIFF_W'(rr_lo_y) + DIFF_W'(rr_hi_y);
	end

	logic                     vld_s2;
	op_t                      op_s2;
	logic signed [CW-1:0]     ax0_s2, ay0_s2, ax1_s2, ay1_s2, bx0_s2, by0_s2, ra_s2, rb_s2;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2, rsum_s2;
	logic signed [DIFF_W-1:0] ex0_s2, ex1_s2, ey0_s2, ey1_s2;
	logic signed [DIFF_W-1:0] al_s2, ar_s2, at_s2, ab_s2;
	logic signed [DIFF_W-1:0] bl_s2, br_s2, bt_s2, bb_s2;
	logic                     rr_hit_s2, rp_hit_s2, pp_hit_s2, rc_edge_s2;
	logic signed [EXT_W-1:0]  rr_cx_s2, rr_cy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_t'(in_s1.operation);
		ax0_s2  <= ax0;
		ay0_s2  <= ay0;
		ax1_s2  <= ax1;
		ay1_s2  <= ay1;
		bx0_s2  <= bx0;
		by0_s2  <= by0;
		ra_s2   <= ax1;
		rb_s2   <= bx1;
		dx_s2   <= DIFF_W'(bx0) - DIFF_W'(ax0);
		dy_s2   <= DIFF_W'(by0) - DIFF_W'(ay0);
		rsum_s2 <= DIFF_W'(ax1) + DIFF_W'(bx1);
		// rect corners relative to the circle centre
		ex0_s2  <= DIFF_W'(ax0) - DIFF_W'(bx0);
		ex1_s2  <= DIFF_W'(ax1) - DIFF_W'(bx0);
		ey0_s2  <= DIFF_W'(ay0) - DIFF_W'(by0);
		ey1_s2  <= DIFF_W'(ay1) - DIFF_W'(by0);
		// rect grown by the radius, and the circle's bounding box
		al_s2   <= DIFF_W'(ax0) - DIFF_W'(bx1);
		ar_s2   <= DIFF_W'(ax1) + DIFF_W'(bx1);
		at_s2   <= DIFF_W'(ay0) - DIFF_W'(bx1);
		ab_s2   <= DIFF_W'(ay1) + DIFF_W'(bx1);
		bl_s2   <= DIFF_W'(bx0) - DIFF_W'(bx1);
		br_s2   <= DIFF_W'(bx0) + DIFF_W'(bx1);
		bt_s2   <= DIFF_W'(by0) - DIFF_W'(bx1);
		bb_s2   <= DIFF_W'(by0) + DIFF_W'(bx1);
		rr_hit_s2  <= !(ax0 > bx1 || ax1 < bx0 || ay0 > by1 || ay1 < by0);
		rp_hit_s2  <= !(ax0 > bx0 || ay0 > by0 || ax1 < bx0 || ay1 < by0);
		pp_hit_s2  <= (trunc_int(ax0) == trunc_int(bx0)) && (trunc_int(ay0) == trunc_int(by0));
		rc_edge_s2 <= (ax0 <= bx0 && bx0 <= ax1) || (ay0 <= by0 && by0 <= ay1);
		// floor of half the sum
		rr_cx_s2   <= EXT_W'(rr_sum_x >>> 1);
		rr_cy_s2   <= EXT_W'(rr_sum_y >>> 1);
	end

	// ---------------------------------------------------------------- stage 3: squares
	logic signed [DIFF_W-1:0] rc_lo_x, rc_hi_x, rc_lo_y, rc_hi_y;
	logic signed [DIFF_W:0]   rc_sum_x, rc_sum_y;
	logic                     s_hit;
	logic signed [EXT_W-1:0]  s_cx, s_cy;

	always_comb begin
		rc_lo_x  = (DIFF_W'(ax0_s2) > bl_s2) ? DIFF_W'(ax0_s2) : bl_s2;
		rc_hi_x  = (DIFF_W'(ax1_s2) < br_s2) ? DIFF_W'(ax1_s2) : br_s2;
		rc_lo_y  = (DIFF_W'(ay0_s2) > bt_s2) ? DIFF_W'(ay0_s2) : bt_s2;
		rc_hi_y  = (DIFF_W'(ay1_s2) < bb_s2) ? DIFF_W'(ay1_s2) : bb_s2;
		rc_sum_x = (DIFF_W+1)'(rc_lo_x) + (DIFF_W+1)'(rc_hi_x);
		rc_sum_y = (DIFF_W+1)'(rc_lo_y) + (DIFF_W+1)'(rc_hi_y);
		s_hit = 1'b0;
		s_cx  = '0;
		s_cy  = '0;
		unique case (op_s2)
			OP_RECT_RECT: begin
				s_hit = rr_hit_s2;
				s_cx  = rr_cx_s2;
				s_cy  = rr_cy_s2;
			end
			OP_RECT_CIRCLE: begin
				s_cx = EXT_W'(rc_sum_x >>> 1);
				s_cy = EXT_W'(rc_sum_y >>> 1);
			end
			OP_RECT_POINT: begin
				s_hit = rp_hit_s2;
				s_cx  = EXT_W'(bx0_s2);
				s_cy  = EXT_W'(by0_s2);
			end
			OP_POINT_POINT: begin
				s_hit = pp_hit_s2;
				s_cx  = EXT_W'(bx0_s2);
				s_cy  = EXT_W'(by0_s2);
			end
			default: begin
				s_hit = 1'b0;
			end
		endcase
	end

	logic                     vld_s3;
	op_t                      op_s3;
	logic [SQ_W-1:0]          dx2_s3, dy2_s3, rsum2_s3, ra2_s3, rb2_s3;
	logic [SQ_W-1:0]          ex02_s3, ex12_s3, ey02_s3, ey12_s3;
	logic                     rsum_neg_s3, rc_edge_s3, rc_go_s3, s_hit_s3;
	logic signed [EXT_W-1:0]  s_cx_s3, s_cy_s3;
	logic signed [DIFF_W-1:0] dx_s3, dy_s3;
	logic signed [CW-1:0]     ra_s3, rb_s3, ax0_s3, ay0_s3, bx0_s3, by0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		op_s3       <= op_s2;
		dx2_s3      <= SQ_W'(dx_s2 * dx_s2);
		dy2_s3      <= SQ_W'(dy_s2 * dy_s2);
		rsum2_s3    <= SQ_W'(rsum_s2 * rsum_s2);
		ra2_s3      <= SQ_W'(ra_s2 * ra_s2);
		rb2_s3      <= SQ_W'(rb_s2 * rb_s2);
		ex02_s3     <= SQ_W'(ex0_s2 * ex0_s2);
		ex12_s3     <= SQ_W'(ex1_s2 * ex1_s2);
		ey02_s3     <= SQ_W'(ey0_s2 * ey0_s2);
		ey12_s3     <= SQ_W'(ey1_s2 * ey1_s2);
		rsum_neg_s3 <= rsum_s2[DIFF_W-1];
		rc_edge_s3  <= rc_edge_s2;
		rc_go_s3    <= !(DIFF_W'(bx0_s2) < al_s2 || DIFF_W'(bx0_s2) > ar_s2 ||
		                 DIFF_W'(by0_s2) < at_s2 || DIFF_W'(by0_s2) > ab_s2);
		s_hit_s3    <= s_hit;
		s_cx_s3     <= s_cx;
		s_cy_s3     <= s_cy;
		dx_s3       <= dx_s2;
		dy_s3       <= dy_s2;
		ra_s3       <= ra_s2;
		rb_s3       <= rb_s2;
		ax0_s3      <= ax0_s2;
		ay0_s3      <= ay0_s2;
		bx0_s3      <= bx0_s2;
		by0_s3      <= by0_s2;
	end

	// ---------------------------------------------------------------- stage 4: distance sums
	logic                     vld_s4;
	op_t                      op_s4;
	logic [SQ_W-1:0]          d2_s4, rsum2_s4, ra2_s4, rb2_s4;
	logic [SQ_W-1:0]          cs00_s4, cs01_s4, cs10_s4, cs11_s4;
	logic                     rsum_neg_s4, rc_edge_s4, rc_go_s4, s_hit_s4;
	logic signed [EXT_W-1:0]  s_cx_s4, s_cy_s4;
	logic signed [DIFF_W-1:0] dx_s4, dy_s4;
	logic signed [CW-1:0]     ra_s4, rb_s4, ax0_s4, ay0_s4, bx0_s4, by0_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		op_s4       <= op_s3;
		d2_s4       <= dx2_s3 + dy2_s3;
		cs00_s4     <= ex02_s3 + ey02_s3;
		cs01_s4     <= ex02_s3 + ey12_s3;
		cs10_s4     <= ex12_s3 + ey02_s3;
		cs11_s4     <= ex12_s3 + ey12_s3;
		rsum2_s4    <= rsum2_s3;
		ra2_s4      <= ra2_s3;
		rb2_s4      <= rb2_s3;
		rsum_neg_s4 <= rsum_neg_s3;
		rc_edge_s4  <= rc_edge_s3;
		rc_go_s4    <= rc_go_s3;
		s_hit_s4    <= s_hit_s3;
		s_cx_s4     <= s_cx_s3;
		s_cy_s4     <= s_cy_s3;
		dx_s4       <= dx_s3;
		dy_s4       <= dy_s3;
		ra_s4       <= ra_s3;
		rb_s4       <= rb_s3;
		ax0_s4      <= ax0_s3;
		ay0_s4      <= ay0_s3;
		bx0_s4      <= bx0_s3;
		by0_s4      <= by0_s3;
	end

	// ---------------------------------------------------------------- stage 5: radius tests
	logic     cc_hit, in_a, in_b, corner_hit;
	sq_side_t side_n;

	always_comb begin
		cc_hit     = !rsum_neg_s4 && (d2_s4 <= rsum2_s4);
		in_a       = !ra_s4[CW-1] && (d2_s4 <= ra2_s4);
		in_b       = !rb_s4[CW-1] && (d2_s4 <= rb2_s4);
		corner_hit = !rb_s4[CW-1] && (cs00_s4 <= rb2_s4 || cs01_s4 <= rb2_s4 ||
		                              cs10_s4 <= rb2_s4 || cs11_s4 <= rb2_s4);
		side_n.hit      = s_hit_s4;
		side_n.need_div = 1'b0;
		side_n.cx       = s_cx_s4;
		side_n.cy       = s_cy_s4;
		side_n.dx       = dx_s4;
		side_n.dy       = dy_s4;
		side_n.ra       = ra_s4;
		side_n.rb       = rb_s4;
		side_n.ax0      = ax0_s4;
		side_n.ay0      = ay0_s4;
		unique case (op_s4)
			OP_CIRCLE_CIRCLE: begin
				side_n.hit = cc_hit;
				// a centre inside the other circle is the contact; else go along the line
				if (in_b) begin
					side_n.cx = EXT_W'(ax0_s4);
					side_n.cy = EXT_W'(ay0_s4);
				end else if (in_a) begin
					side_n.cx = EXT_W'(bx0_s4);
					side_n.cy = EXT_W'(by0_s4);
				end else begin
					side_n.need_div = cc_hit;
				end
			end
			OP_RECT_CIRCLE: begin
				side_n.hit = rc_edge_s4 ? rc_go_s4 : corner_hit;
			end
			OP_CIRCLE_POINT: begin
				side_n.hit = in_a;
				side_n.cx  = EXT_W'(bx0_s4);
				side_n.cy  = EXT_W'(by0_s4);
			end
			default: begin
				side_n.hit = s_hit_s4;
			end
		endcase
	end

	logic            vld_s5;
	logic [SQ_W-1:0] d2_s5;
	sq_side_t        side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		d2_s5   <= d2_s4;
		side_s5 <= side_n;
	end

	// ---------------------------------------------------------------- root pipeline
	logic [ROOT_W-1:0] root_d;
	logic [ROOT_W-1:0] sq_vld_q;
	sq_side_t          sq_side_q [ROOT_W];

	spct_isqrt u_isqrt (
		.clk      (clk),
		.radicand (d2_s5),
		.root     (root_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld_q <= '0;
		else
			sq_vld_q <= {sq_vld_q[ROOT_W-2:0], vld_s5};
	end

	// hold each word's state level with its root
	always_ff @(posedge clk) begin
		sq_side_q[0] <= side_s5;
		for (int k = 1; k < ROOT_W; k++)
			sq_side_q[k] <= sq_side_q[k-1];
	end

	// ---------------------------------------------------------------- product stage
	sq_side_t                sq_out;
	logic signed [LEN_W-1:0] len2;

	assign sq_out = sq_side_q[ROOT_W-1];
	assign len2   = LEN_W'($signed({1'b0, root_d})) + LEN_W'($signed(sq_out.ra)) -
	                LEN_W'($signed(sq_out.rb));

	logic                    vld_m;
	logic signed [NUM_W-1:0] prod_x_m, prod_y_m;
	logic [DEN_W-1:0]        den_m;
	sq_side_t                side_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m <= 1'b0;
		else
			vld_m <= sq_vld_q[ROOT_W-1];
	end

	always_ff @(posedge clk) begin
		prod_x_m <= NUM_W'($signed(sq_out.dx) * len2);
		prod_y_m <= NUM_W'($signed(sq_out.dy) * len2);
		// a zero distance divides by two
		den_m    <= (root_d == '0) ? DEN_W'(2) : {root_d, 1'b0};
		side_m   <= sq_out;
	end

	// ---------------------------------------------------------------- magnitude stage
	logic             vld_a;
	logic [NUM_W-1:0] mag_x_a, mag_y_a;
	logic [DEN_W-1:0] den_a;
	dv_side_t         side_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_a <= 1'b0;
		else
			vld_a <= vld_m;
	end

	always_ff @(posedge clk) begin
		mag_x_a         <= prod_x_m[NUM_W-1] ? NUM_W'(-prod_x_m) : NUM_W'(prod_x_m);
		mag_y_a         <= prod_y_m[NUM_W-1] ? NUM_W'(-prod_y_m) : NUM_W'(prod_y_m);
		den_a           <= den_m;
		side_a.hit      <= side_m.hit;
		side_a.need_div <= side_m.need_div;
		side_a.cx       <= side_m.cx;
		side_a.cy       <= side_m.cy;
		side_a.ax0      <= side_m.ax0;
		side_a.ay0      <= side_m.ay0;
		side_a.sgn_x    <= prod_x_m[NUM_W-1];
		side_a.sgn_y    <= prod_y_m[NUM_W-1];
	end

	// ---------------------------------------------------------------- quotient pipelines
	logic [QUO_W-1:0] quo_x, quo_y;
	logic             nz_x, nz_y;
	logic [QUO_W-1:0] dv_vld_q;
	dv_side_t         dv_side_q [QUO_W];

	spct_div u_div_x (
		.clk      (clk),
		.dividend (mag_x_a),
		.divisor  (den_a),
		.quotient (quo_x),
		.rem_nz   (nz_x)
	);

	spct_div u_div_y (
		.clk      (clk),
		.dividend (mag_y_a),
		.divisor  (den_a),
		.quotient (quo_y),
		.rem_nz   (nz_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_q <= '0;
		else
			dv_vld_q <= {dv_vld_q[QUO_W-2:0], vld_a};
	end

	always_ff @(posedge clk) begin
		dv_side_q[0] <= side_a;
		for (int k = 1; k < QUO_W; k++)
			dv_side_q[k] <= dv_side_q[k-1];
	end

	// ---------------------------------------------------------------- output stage
	dv_side_t                dv_out;
	logic signed [QUO_W:0]   qs_x, qs_y;
	logic signed [EXT_W-1:0] px, py;

	always_comb begin
		dv_out = dv_side_q[QUO_W-1];
		// floor division: a negative quotient with a remainder steps down by one
		qs_x = $signed({1'b0, quo_x});
		qs_y = $signed({1'b0, quo_y});
		if (dv_out.sgn_x)
			qs_x = -qs_x - (QUO_W+1)'(nz_x);
		if (dv_out.sgn_y)
			qs_y = -qs_y - (QUO_W+1)'(nz_y);
		if (dv_out.need_div) begin
			px = EXT_W'($signed(dv_out.ax0)) + EXT_W'(qs_x);
			py = EXT_W'($signed(dv_out.ay0)) + EXT_W'(qs_y);
		end else begin
			px = dv_out.cx;
			py = dv_out.cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv_vld_q[QUO_W-1];
	end

	// drop the contact on a miss
	always_ff @(posedge clk) begin
		result.hit       <= dv_out.hit;
		result.contact_x <= dv_out.hit ? sat_coord(px) : '0;
		result.contact_y <= dv_out.hit ? sat_coord(py) : '0;
	end

endmodule

// File: rtl/spct_checker.sv
// Port-level checks of the shape pair collision test unit, bound to its top level.
// Depends on spct_pkg and shape_pair_collision_test_unit.
`timescale 1ns / 1ps

module spct_checker
	import spct_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input cmd_word_t    cmd,
	input logic         done,
	input result_word_t result
);

	// every accepted word comes out after the fixed latency
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted word did not come out after the pipeline latency");

	// no result without a word accepted the latency before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result with no matching accepted word");

	// a miss carries a zero contact
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.contact_x == '0 && result.contact_y == '0)
		else $error("miss with a non-zero contact");

	// a point-point hit reports point B unchanged
	a_point_contact: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit &&
		$past(start && !busy && cmd.operation == OP_POINT_POINT, LATENCY) |->
		result.contact_x == $past(cmd.b_x0, LATENCY) &&
		result.contact_y == $past(cmd.b_y0, LATENCY))
		else $error("point-point contact differs from point B");

endmodule

bind shape_pair_collision_test_unit spct_checker u_spct_checker (.*);

// File: bench/shape_pair_collision_checker.sv
// Checker for the shape pair collision test unit: predicts each word's hit flag and contact point.
// Depends on spct_pkg; watches the command and result channels of the block.
`timescale 1ns / 1ps

module shape_pair_collision_checker
	import spct_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         busy,
	input  cmd_word_t    cmd,
	input  logic         done,
	input  result_word_t result,
	output int           fail_count,
	output int           pending
);

	result_word_t contact_queue[$];

	function automatic longint div_floor(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && ((num < 0) != (den < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic longint root_floor(longint n);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
				r = r + (longint'(1) << b);
		end
		return r;
	endfunction

	function automatic bit in_radius(longint d2, longint r);
		return r >= 0 && d2 <= r * r;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clamp(longint v);
		longint hi;
		hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
		if (v > hi)
			v = hi;
		if (v < -hi - 1)
			v = -hi - 1;
		return v[COORD_WIDTH-1:0];
	endfunction

	function automatic result_word_t predict_contact(cmd_word_t c);
		result_word_t res;
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		longint dx, dy, d2, root_d, len2, r, cx, cy, one;
		longint xs[2], ys[2];
		bit hit, go;
		ax0 = c.a_x0; ay0 = c.a_y0; ax1 = c.a_x1; ay1 = c.a_y1;
		bx0 = c.b_x0; by0 = c.b_y0; bx1 = c.b_x1; by1 = c.b_y1;
		hit = 0; cx = 0; cy = 0;
		case (c.operation)
			OP_RECT_RECT: begin
				if (!(ax0 > bx1 || ax1 < bx0 || ay0 > by1 || ay1 < by0)) begin
					hit = 1;
					cx = div_floor((ax0 > bx0 ? ax0 : bx0) + (ax1 < bx1 ? ax1 : bx1), 2);
					cy = div_floor((ay0 > by0 ? ay0 : by0) + (ay1 < by1 ? ay1 : by1), 2);
				end
			end
			OP_CIRCLE_CIRCLE: begin
				dx = bx0 - ax0; dy = by0 - ay0;
				d2 = dx * dx + dy * dy;
				if (in_radius(d2, ax1 + bx1)) begin
					hit = 1;
					if (in_radius(d2, bx1)) begin
						cx = ax0; cy = ay0;
					end else if (in_radius(d2, ax1)) begin
						cx = bx0; cy = by0;
					end else begin
						root_d = root_floor(d2);
						len2 = root_d + ax1 - bx1;
						if (root_d < 1)
							root_d = 1;
						cx = ax0 + div_floor(dx * len2, 2 * root_d);
						cy = ay0 + div_floor(dy * len2, 2 * root_d);
					end
				end
			end
			OP_RECT_CIRCLE: begin
				r = bx1;
				go = 0;
				if ((ax0 <= bx0 && bx0 <= ax1) || (ay0 <= by0 && by0 <= ay1)) begin
					go = !(bx0 < ax0 - r || bx0 > ax1 + r || by0 < ay0 - r || by0 > ay1 + r);
				end else begin
					xs[0] = ax0; xs[1] = ax1; ys[0] = ay0; ys[1] = ay1;
					for (int i = 0; i < 2; i++)
						for (int j = 0; j < 2; j++)
							if (in_radius((xs[i] - bx0) * (xs[i] - bx0) +
								(ys[j] - by0) * (ys[j] - by0), r))
								go = 1;
				end
				if (go) begin
					hit = 1;
					cx = div_floor((ax0 > bx0 - r ? ax0 : bx0 - r) +
						(ax1 < bx0 + r ? ax1 : bx0 + r), 2);
					cy = div_floor((ay0 > by0 - r ? ay0 : by0 - r) +
						(ay1 < by0 + r ? ay1 : by0 + r), 2);
				end
			end
			OP_RECT_POINT: begin
				if (!(ax0 > bx0 || ay0 > by0 || ax1 < bx0 || ay1 < by0)) begin
					hit = 1; cx = bx0; cy = by0;
				end
			end
			OP_CIRCLE_POINT: begin
				dx = bx0 - ax0; dy = by0 - ay0;
				if (in_radius(dx * dx + dy * dy, ax1)) begin
					hit = 1; cx = bx0; cy = by0;
				end
			end
			OP_POINT_POINT: begin
				one = longint'(1) << FRAC_BITS;
				// integer division in SV truncates toward zero
				if (ax0 / one == bx0 / one && ay0 / one == by0 / one) begin
					hit = 1; cx = bx0; cy = by0;
				end
			end
			default: hit = 0;
		endcase
		res.hit = hit;
		res.contact_x = hit ? clamp(cx) : '0;
		res.contact_y = hit ? clamp(cy) : '0;
		return res;
	endfunction

	assign pending = contact_queue.size();

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		int           errs;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			errs = 0;
			if (start && !busy)
				contact_queue.insert(contact_queue.size(), predict_contact(cmd));
			if (done) begin
				if (contact_queue.size() == 0) begin
					$error("result word with nothing expected");
					errs = errs + 1;
				end else begin
					want = contact_queue.pop_front();
					if (result.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, result.hit);
						errs = errs + 1;
					end
					if (result.contact_x !== want.contact_x) begin
						$error("contact_x: expected %0d, got %0d",
							want.contact_x, result.contact_x);
						errs = errs + 1;
					end
					if (result.contact_y !== want.contact_y) begin
						$error("contact_y: expected %0d, got %0d",
							want.contact_y, result.contact_y);
						errs = errs + 1;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// File: bench/shape_pair_collision_test_unit_tb.sv
// Top of the testbench for the shape pair collision test unit: clock, reset, stimulus, verdict.
// Depends on spct_pkg, the block and shape_pair_collision_checker.
`timescale 1ns / 1ps

module shape_pair_collision_test_unit_tb;
	import spct_pkg::*;

	localparam int RANDOM_WORDS = 1880;
	localparam int STALL_LIMIT  = 2000;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	cmd_word_t    cmd;
	logic         done;
	result_word_t result;
	int           fail_count;
	int           pending;
	int           idle_cycles;
	cmd_word_t    directed_q[$];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	shape_pair_collision_test_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	shape_pair_collision_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Random coordinate: mostly small values near each other, sometimes the full range
	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1:    return COORD_WIDTH'($urandom());
			2:       return $urandom_range(0, 1) ? {1'b0, {(COORD_WIDTH-1){1'b1}}}
				: {1'b1, {(COORD_WIDTH-1){1'b0}}};
			default: return COORD_WIDTH'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	// Build a shape pair where most pairs are geometrically plausible
	function automatic cmd_word_t rand_word();
		cmd_word_t c;
		c.operation = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		c.a_x0 = rand_coord();
		c.a_y0 = rand_coord();
		c.b_x0 = rand_coord();
		c.b_y0 = rand_coord();
		c.a_y1 = rand_coord();
		c.b_y1 = rand_coord();
		if ($urandom_range(0, 3) != 0) begin
			// well-formed words have rects with non-negative extent, non-negative radii and shapes nearby
			c.a_x1 = c.a_x0 + COORD_WIDTH'($urandom_range(0, 2048));
			c.a_y1 = c.a_y0 + COORD_WIDTH'($urandom_range(0, 2048));
			c.b_x0 = c.a_x0 + COORD_WIDTH'($signed($urandom_range(0, 4095)) - 2048);
			c.b_y0 = c.a_y0 + COORD_WIDTH'($signed($urandom_range(0, 4095)) - 2048);
			if (c.operation == OP_CIRCLE_CIRCLE || c.operation == OP_CIRCLE_POINT
				|| c.operation == OP_RECT_CIRCLE) begin
				c.a_x1 = (c.operation == OP_RECT_CIRCLE) ? c.a_x1
					: COORD_WIDTH'($urandom_range(0, 2048));
				c.b_x1 = COORD_WIDTH'($urandom_range(0, 2048));
			end else begin
				c.b_x1 = c.b_x0 + COORD_WIDTH'($urandom_range(0, 2048));
				c.b_y1 = c.b_y0 + COORD_WIDTH'($urandom_range(0, 2048));
			end
		end else begin
			c.a_x1 = rand_coord();
			c.b_x1 = rand_coord();
		end
		return c;
	endfunction

	function automatic cmd_word_t make_word(op_t op, int ax0, int ay0, int ax1, int ay1,
		int bx0, int by0, int bx1, int by1);
		cmd_word_t c;
		c.operation = op;
		c.a_x0 = COORD_WIDTH'(ax0); c.a_y0 = COORD_WIDTH'(ay0);
		c.a_x1 = COORD_WIDTH'(ax1); c.a_y1 = COORD_WIDTH'(ay1);
		c.b_x0 = COORD_WIDTH'(bx0); c.b_y0 = COORD_WIDTH'(by0);
		c.b_x1 = COORD_WIDTH'(bx1); c.b_y1 = COORD_WIDTH'(by1);
		return c;
	endfunction

	// Append a word to the directed list
	function automatic void queue_word(cmd_word_t c);
		directed_q = {directed_q, c};
	endfunction

	// Hold the word on the command port until it is taken, then optionally idle
	task automatic send_word(cmd_word_t c, int gap);
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			cmd   <= '0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Watchdog: count cycles in which no word moves either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("shape_pair_collision_test_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int maxv, minv;
		maxv = (1 << (COORD_WIDTH - 1)) - 1;
		minv = -(1 << (COORD_WIDTH - 1));
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each operation, hits and misses, extremes and the special cases
		queue_word(make_word(OP_RECT_RECT, 0, 0, 512, 512, 256, 256, 1024, 1024));
		queue_word(make_word(OP_RECT_RECT, 0, 0, 100, 100, 200, 200, 300, 300));
		queue_word(make_word(OP_RECT_RECT, minv, minv, maxv, maxv,
			minv, minv, maxv, maxv));
		// inverted rect compared as given
		queue_word(make_word(OP_RECT_RECT, 500, 500, 100, 100, 0, 0, 600, 600));
		// rounding of negative midpoints toward minus infinity
		queue_word(make_word(OP_RECT_RECT, -3, -3, 0, 0, -3, -3, 0, 0));
		queue_word(make_word(OP_CIRCLE_CIRCLE, 0, 0, 1000, 0, 1500, 0, 1000, 0));
		queue_word(make_word(OP_CIRCLE_CIRCLE, 0, 0, 2000, 0, 100, 50, 100, 0));
		queue_word(make_word(OP_CIRCLE_CIRCLE, 0, 0, 100, 0, 50, 50, 2000, 0));
		queue_word(make_word(OP_CIRCLE_CIRCLE, 0, 0, 100, 0, 5000, 0, 100, 0));
		queue_word(make_word(OP_CIRCLE_CIRCLE, 10, 10, -5, 0, 10, 10, -5, 0));
		queue_word(make_word(OP_CIRCLE_CIRCLE, minv, minv, maxv, 0,
			maxv, maxv, maxv, 0));
		queue_word(make_word(OP_CIRCLE_CIRCLE, 0, 0, 300, 0, 300, 400, 300, 0));
		queue_word(make_word(OP_RECT_CIRCLE, 0, 0, 1000, 1000, 500, 1200, 300, 0));
		queue_word(make_word(OP_RECT_CIRCLE, 0, 0, 1000, 1000, 1100, 1100, 200, 0));
		queue_word(make_word(OP_RECT_CIRCLE, 0, 0, 1000, 1000, 1500, 1500, 200, 0));
		queue_word(make_word(OP_RECT_CIRCLE, 0, 0, 10, 10, maxv, maxv, maxv, 0));
		queue_word(make_word(OP_RECT_POINT, 0, 0, 100, 100, 100, 0, 0, 0));
		queue_word(make_word(OP_RECT_POINT, 0, 0, 100, 100, 101, 50, 0, 0));
		queue_word(make_word(OP_CIRCLE_POINT, 0, 0, 500, 0, 300, 400, 0, 0));
		queue_word(make_word(OP_CIRCLE_POINT, 0, 0, 499, 0, 300, 400, 0, 0));
		// truncation toward zero: -0.5 and +0.5 share integer part zero
		queue_word(make_word(OP_POINT_POINT, -128, 128, 0, 0, 128, -128, 0, 0));
		queue_word(make_word(OP_POINT_POINT, -256, 0, 0, 0, 0, 0, 0, 0));
		queue_word(make_word(op_t'(3'd6), 0, 0, 100, 100, 0, 0, 100, 100));
		queue_word(make_word(op_t'(3'd7), maxv, minv, -1, 0, -1, maxv, minv, 0));
		foreach (directed_q[i])
			send_word(directed_q[i], (i % 3 == 0) ? int'($urandom_range(0, 5)) : 0);

		// Random part; pause once midway until the pipeline drains
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2) begin
				start <= 1'b0;
				cmd   <= '0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			// alternate bursts with no gaps and stretches with random gaps
			send_word(rand_word(), ((n / 64) % 2 == 0) ? 0 : int'($urandom_range(0, 5)));
		end
		start <= 1'b0;
		cmd   <= '0;

		// drain, then allow the pipeline latency once more for stray words
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("shape_pair_collision_test_unit_tb: PASS");
		else
			$display("shape_pair_collision_test_unit_tb: FAIL");
		$finish;
	end

endmodule
